// ----- src/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types for the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Default width of the tested number
    localparam int NUMBER_WIDTH_DEF = 32;

    // Status returned by the remainder unit to the sequencer
    typedef struct packed {
        logic done;      // one-cycle pulse, remainder is final
        logic rem_zero;  // remainder of the finished division is zero
    } t_div_rsp;

endpackage

// ----- src/tdpt_divider.sv -----
// ----------------------------------------------------------------------------
// tdpt_divider
// Shared restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_divider
    import tdpt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [NUMBER_WIDTH-1:0] i_divisor,
    output t_div_rsp                o_rsp
);

    localparam int CW = $clog2(NUMBER_WIDTH + 1);

    logic                    r_busy;
    logic                    n_busy;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           n_cnt;
    logic [NUMBER_WIDTH-1:0] r_dvd;
    logic [NUMBER_WIDTH-1:0] n_dvd;
    logic [NUMBER_WIDTH-1:0] r_dvs;
    logic [NUMBER_WIDTH-1:0] n_dvs;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] n_rem;
    t_div_rsp                r_rsp;
    t_div_rsp                n_rsp;

    logic [NUMBER_WIDTH:0]   trial;
    logic [NUMBER_WIDTH:0]   diff;
    logic                    fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_dvd[NUMBER_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy       = r_busy;
        n_cnt        = r_cnt;
        n_dvd        = r_dvd;
        n_dvs        = r_dvs;
        n_rem        = r_rem;
        n_rsp.done     = 1'b0;
        n_rsp.rem_zero = r_rsp.rem_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NUMBER_WIDTH);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = fits ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
            n_dvd = {r_dvd[NUMBER_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy         = 1'b0;
                n_rsp.done     = 1'b1;
                n_rsp.rem_zero = (n_rem == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rsp    <= '0;
        end else begin
            r_busy   <= n_busy;
            r_rsp    <= n_rsp;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_rsp = r_rsp;

    // A finished division always follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp.done |-> $past(r_busy))
        else $error("remainder done without a running division");

    // The partial remainder stays below the divisor while busy
    a_rem_below_dvs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_start)) |-> (r_rem < r_dvs))
        else $error("partial remainder not reduced");

endmodule

// ----- src/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Reports whether a signed number is prime by trial division.
// ----------------------------------------------------------------------------
// Takes one two's complement number per transfer and returns one is_prime bit.
// Negative values, zero and one give 0; two and three give 1; even values give
// 0 right away. Any other value is divided by 3, then by 5, 7, ... while the
// divisor squared does not exceed the value, and a zero remainder ends with 0.
// All remainders come from one shared restoring divider that produces one bit
// per cycle, so each trial divisor passes through the start, the NUMBER_WIDTH
// divider steps, the done response and the bound check. An item settled
// without division goes straight from the idle state to the finish state, and
// a prime runs through all the odd trial divisors up to sqrt(number). The input
// stall is high while an item is being worked on; a finished result waits in
// the output register, so the next number can be taken while it is held.
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [NUMBER_WIDTH-1:0] i_number,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_is_prime
);

    localparam int NW = NUMBER_WIDTH;
    // The running square never passes 2^NW, two extra bits keep it exact
    localparam int SW = NUMBER_WIDTH + 2;

    typedef enum logic [1:0] {
        S_IDLE,   // wait for a number
        S_DIV,    // shared divider works on the current divisor
        S_CHECK,  // compare divisor squared against the number
        S_FIN     // hold the answer until the output register is free
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic [NW-1:0]  r_v;
    logic [NW-1:0]  n_v;
    logic [NW-1:0]  r_d;
    logic [NW-1:0]  n_d;
    logic [SW-1:0]  r_sq;
    logic [SW-1:0]  n_sq;
    logic           r_res;
    logic           n_res;
    logic           r_div_start;
    logic           n_div_start;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           r_out_prime;
    logic           n_out_prime;

    logic [NW-1:0]  num_u;
    t_div_rsp       div_rsp;

    assign num_u = i_number;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_d         = r_d;
        n_sq        = r_sq;
        n_res       = r_res;
        n_div_start = 1'b0;
        // drop the held result once it transfers
        n_out_valid = r_out_valid && i_stall;
        n_out_prime = r_out_prime;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_v = num_u;
                    if (num_u[NW-1] || (num_u < NW'(2))) begin
                        // negative, zero or one
                        n_res   = 1'b0;
                        n_state = S_FIN;
                    end else if (num_u <= NW'(3)) begin
                        n_res   = 1'b1;
                        n_state = S_FIN;
                    end else if (!num_u[0]) begin
                        n_res   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        // first trial divisor is 3, its square 9
                        n_d         = NW'(3);
                        n_sq        = SW'(9);
                        n_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        n_res   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
                        n_d     = r_d + NW'(2);
                        n_sq    = r_sq + {r_d, 2'b00} + SW'(4);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq > {2'b00, r_v}) begin
                    n_res   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_v         <= n_v;
        r_d         <= n_d;
        r_sq        <= n_sq;
        r_res       <= n_res;
        r_out_prime <= n_out_prime;
    end

    tdpt_divider #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_rsp      (div_rsp)
    );

    // hold off new numbers while one is in work
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

    // A division is only launched on entry to the divide state
    a_start_on_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV && ($past(r_state) == S_IDLE
                         || $past(r_state) == S_CHECK)))
        else $error("division started outside the divide state entry");

    // Trial divisors and their squares stay odd
    a_divisor_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_DIV) |-> (r_d[0] && r_sq[0]))
        else $error("trial divisor or square became even");

    // No even value above two is ever reported prime
    a_even_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_res) |-> (r_v[0] || r_v == NW'(2)))
        else $error("even number reported prime");

endmodule
